// ===== sv/plmc_pkg.sv =====
// Shared types and constants of the priority LED mode controller.
`timescale 1ns / 1ps
`default_nettype none

package plmc_pkg;

  // LED modes, in rising priority.
  typedef enum logic [1:0] {
    MODE_STATUS = 2'd0,
    MODE_FLASH  = 2'd1,
    MODE_OTA    = 2'd2
  } led_mode_e;

  // Command codes carried in the mode field of an input transaction.
  typedef enum logic [2:0] {
    CMD_SET_MODE      = 3'd0,
    CMD_STATUS_UPDATE = 3'd1,
    CMD_STATUS_DIRECT = 3'd2,
    CMD_FLASH_REQUEST = 3'd3,
    CMD_FLASH_RELEASE = 3'd4,
    CMD_FLASH_REFRESH = 3'd5,
    CMD_OTA_UPDATE    = 3'd6
  } cmd_e;

  // Flash requester codes.
  localparam logic SRC_MANUAL = 1'b0;

  // Field widths fixed by the channel format.
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned TIME_MS_W  = 32;
  localparam int unsigned INTERVAL_W = 16;

  // Configuration register indexes and reset values.
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_STATUS_INTERVAL = 2'd0;
  localparam logic [1:0] REG_OTA_INTERVAL    = 2'd1;
  localparam logic [1:0] REG_OTA_LEVEL       = 2'd2;
  localparam logic [INTERVAL_W-1:0] STATUS_INTERVAL_RST = 16'd500;
  localparam logic [INTERVAL_W-1:0] OTA_INTERVAL_RST    = 16'd100;
  localparam logic [LEVEL_W-1:0]    OTA_LEVEL_RST       = 8'd255;

  // One input transaction as held in the input register.
  typedef struct packed {
    logic [2:0]           mode;
    logic [1:0]           target_mode;
    logic                 connected;
    logic                 enabled;
    logic                 lit;
    logic [LEVEL_W-1:0]   brightness;
    logic                 flash_source;
    logic [LEVEL_W-1:0]   intensity;
    logic [TIME_MS_W-1:0] time_ms;
  } in_item_t;

  // One result transaction as held in the result register.
  typedef struct packed {
    logic               pwm_written;
    logic [LEVEL_W-1:0] pwm_level;
    logic [1:0]         active_mode;
    logic               change_blocked;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/plmc_in_if.sv =====
// Input channel interface of the priority LED mode controller.
`timescale 1ns / 1ps
`default_nettype none

interface plmc_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        mode;
  logic [1:0]                        target_mode;
  logic                              connected;
  logic                              enabled;
  logic                              lit;
  logic [plmc_pkg::LEVEL_W-1:0]      brightness;
  logic                              flash_source;
  logic [plmc_pkg::LEVEL_W-1:0]      intensity;
  logic [plmc_pkg::TIME_MS_W-1:0]    time_ms;

  modport source (
    output valid, mode, target_mode, connected, enabled, lit, brightness,
           flash_source, intensity, time_ms,
    input  ready
  );

  modport sink (
    input  valid, mode, target_mode, connected, enabled, lit, brightness,
           flash_source, intensity, time_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/plmc_out_if.sv =====
// Result channel interface of the priority LED mode controller.
`timescale 1ns / 1ps
`default_nettype none

interface plmc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         pwm_written;
  logic [plmc_pkg::LEVEL_W-1:0] pwm_level;
  logic [1:0]                   active_mode;
  logic                         change_blocked;

  modport source (
    output valid, pwm_written, pwm_level, active_mode, change_blocked,
    input  ready
  );

  modport sink (
    input  valid, pwm_written, pwm_level, active_mode, change_blocked,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/plmc_blink_tick.sv =====
// Blink timer check: wrapping elapsed time compared against an interval.
`timescale 1ns / 1ps
`default_nettype none

module plmc_blink_tick #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic [TIME_WIDTH-1:0]               now_i,
  input  wire logic [TIME_WIDTH-1:0]               last_i,
  input  wire logic [plmc_pkg::INTERVAL_W-1:0]     interval_i,
  output logic                                     due_o
);

  logic [TIME_WIDTH-1:0] elapsed;

  // The subtraction wraps modulo 2^TIME_WIDTH, so a timestamp wrap is harmless.
  assign elapsed = now_i - last_i;
  assign due_o   = (elapsed >= TIME_WIDTH'(interval_i));

endmodule

`default_nettype wire

// ===== sv/priority_led_mode_controller.sv =====
// Top level of the priority LED mode controller.
//
// Usage: commands arrive as transactions on in_i and each one produces
// exactly one result transaction on out_o (PWM write flag, PWM level,
// active mode, blocked flag). Both channels use valid/ready handshakes.
// An accepted command is held in an input register; the mode logic evaluates
// it against the held state and loads the result register when that is free
// or drains. Throughput is one command per cycle while results are taken: the
// input register refills while the result register is being taken, and the
// single-pass mode logic sets that rate. When the receiver stalls, the result
// register holds its transaction and the input register holds the next one;
// in_i.ready drops only when both are full. The APB port writes the blink
// intervals and the OTA lit level (addresses 0x0, 0x4, 0x8) and reads them
// back; the user must write it only while the block is idle, which the block
// itself does not enforce. Reset clears all mode state to status mode, off,
// with no flash requests held, and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module priority_led_mode_controller #(
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned PWM_WIDTH  = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  plmc_in_if.sink                            in_i,
  plmc_out_if.source                         out_o,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [plmc_pkg::PADDR_W-1:0]  paddr_i,
  input  wire logic [31:0]                   pwdata_i,
  output logic [31:0]                        prdata_o,
  output logic                               pready_o
);

  // Configuration registers.
  logic [plmc_pkg::INTERVAL_W-1:0] status_interval_q;
  logic [plmc_pkg::INTERVAL_W-1:0] ota_interval_q;
  logic [plmc_pkg::LEVEL_W-1:0]    ota_level_q;
  logic                            cfg_write;
  logic [1:0]                      cfg_index;

  // Pipeline registers.
  logic                 in_valid_q;
  plmc_pkg::in_item_t   item_q;
  logic                 out_valid_q;
  plmc_pkg::out_item_t  result_q;
  plmc_pkg::out_item_t  result_d;
  logic                 advance;
  logic                 fire;

  // Mode state.
  plmc_pkg::led_mode_e   mode_q,         mode_d;
  logic                  status_on_q,    status_on_d;
  logic [TIME_WIDTH-1:0] status_last_q,  status_last_d;
  logic [PWM_WIDTH-1:0]  flash_shown_q,  flash_shown_d;
  logic                  ota_on_q,       ota_on_d;
  logic [TIME_WIDTH-1:0] ota_last_q,     ota_last_d;
  logic                  man_act_q,      man_act_d;
  logic [PWM_WIDTH-1:0]  man_lvl_q,      man_lvl_d;
  logic                  auto_act_q,     auto_act_d;
  logic [PWM_WIDTH-1:0]  auto_lvl_q,     auto_lvl_d;
  logic [PWM_WIDTH-1:0]  last_lvl_q,     last_lvl_d;

  // Step values derived from the held command.
  logic                  wrote;
  logic                  blocked;
  logic [TIME_WIDTH-1:0] now;
  logic [PWM_WIDTH-1:0]  bright;
  logic [PWM_WIDTH-1:0]  inten;
  logic [PWM_WIDTH-1:0]  ota_lit_level;
  logic [PWM_WIDTH-1:0]  req_lvl;
  logic [PWM_WIDTH-1:0]  drive_lvl;
  logic                  status_due;
  logic                  ota_due;

  // APB access: always ready, register index taken from the word address.
  assign pready_o  = 1'b1;
  assign cfg_index = paddr_i[3:2];
  assign cfg_write = psel_i && penable_i && pwrite_i;

  always_comb begin
    prdata_o = '0;
    unique case (cfg_index)
      plmc_pkg::REG_STATUS_INTERVAL: prdata_o = 32'(status_interval_q);
      plmc_pkg::REG_OTA_INTERVAL:    prdata_o = 32'(ota_interval_q);
      plmc_pkg::REG_OTA_LEVEL:       prdata_o = 32'(ota_level_q);
      default:                       prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_interval_q <= plmc_pkg::STATUS_INTERVAL_RST;
      ota_interval_q    <= plmc_pkg::OTA_INTERVAL_RST;
      ota_level_q       <= plmc_pkg::OTA_LEVEL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        plmc_pkg::REG_STATUS_INTERVAL: status_interval_q <= pwdata_i[15:0];
        plmc_pkg::REG_OTA_INTERVAL:    ota_interval_q    <= pwdata_i[15:0];
        plmc_pkg::REG_OTA_LEVEL:       ota_level_q       <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: the mode logic fires when the result register is free or drains.
  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;

  // Field conversion into internal widths.
  assign now           = TIME_WIDTH'(item_q.time_ms);
  assign bright        = PWM_WIDTH'(item_q.brightness);
  assign inten         = PWM_WIDTH'(item_q.intensity);
  assign ota_lit_level = PWM_WIDTH'(ota_level_q);

  // Blink timers for status and OTA modes.
  plmc_blink_tick #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_status_tick (
    .now_i      (now),
    .last_i     (status_last_q),
    .interval_i (status_interval_q),
    .due_o      (status_due)
  );

  plmc_blink_tick #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ota_tick (
    .now_i      (now),
    .last_i     (ota_last_q),
    .interval_i (ota_interval_q),
    .due_o      (ota_due)
  );

  // Mode logic: one pass over the held command, updating state in order.
  always_comb begin
    mode_d        = mode_q;
    status_on_d   = status_on_q;
    status_last_d = status_last_q;
    flash_shown_d = flash_shown_q;
    ota_on_d      = ota_on_q;
    ota_last_d    = ota_last_q;
    man_act_d     = man_act_q;
    man_lvl_d     = man_lvl_q;
    auto_act_d    = auto_act_q;
    auto_lvl_d    = auto_lvl_q;
    last_lvl_d    = last_lvl_q;
    wrote         = 1'b0;
    blocked       = 1'b0;
    req_lvl       = '0;
    drive_lvl     = '0;

    unique case (plmc_pkg::cmd_e'(item_q.mode))
      plmc_pkg::CMD_SET_MODE: begin
        // A code above OTA or the current mode itself is ignored.
        if (item_q.target_mode <= 2'(plmc_pkg::MODE_OTA) && item_q.target_mode != mode_q) begin
          if (item_q.target_mode != 2'(plmc_pkg::MODE_STATUS) &&
              item_q.target_mode < mode_q) begin
            blocked = 1'b1;
          end else begin
            mode_d = plmc_pkg::led_mode_e'(item_q.target_mode);
            unique case (mode_d)
              plmc_pkg::MODE_STATUS: begin
                status_on_d   = 1'b0;
                status_last_d = '0;
              end
              plmc_pkg::MODE_FLASH: flash_shown_d = '0;
              default: begin
                ota_on_d   = 1'b0;
                ota_last_d = '0;
              end
            endcase
          end
        end
      end

      plmc_pkg::CMD_STATUS_UPDATE: begin
        if (mode_q == plmc_pkg::MODE_STATUS) begin
          priority if (!item_q.enabled || bright == '0) begin
            wrote       = (last_lvl_q != '0);
            last_lvl_d  = '0;
            status_on_d = 1'b0;
          end else if (item_q.connected) begin
            if (!status_on_q) begin
              wrote       = (last_lvl_q != bright);
              last_lvl_d  = bright;
              status_on_d = 1'b1;
            end
          end else if (status_due) begin
            status_on_d   = !status_on_q;
            drive_lvl     = status_on_d ? bright : '0;
            wrote         = (last_lvl_q != drive_lvl);
            last_lvl_d    = drive_lvl;
            status_last_d = now;
          end
        end
      end

      plmc_pkg::CMD_STATUS_DIRECT: begin
        if (mode_q == plmc_pkg::MODE_STATUS) begin
          status_on_d = item_q.lit;
          drive_lvl   = item_q.lit ? bright : '0;
          wrote       = (last_lvl_q != drive_lvl);
          last_lvl_d  = drive_lvl;
        end
      end

      plmc_pkg::CMD_FLASH_REQUEST,
      plmc_pkg::CMD_FLASH_RELEASE,
      plmc_pkg::CMD_FLASH_REFRESH: begin
        // Update the held requests, then decide whether to apply them.
        logic apply;
        apply = 1'b0;
        if (plmc_pkg::cmd_e'(item_q.mode) == plmc_pkg::CMD_FLASH_REFRESH) begin
          apply = 1'b1;
        end else if (plmc_pkg::cmd_e'(item_q.mode) == plmc_pkg::CMD_FLASH_REQUEST) begin
          if (item_q.flash_source == plmc_pkg::SRC_MANUAL) begin
            if (!man_act_q || man_lvl_q != inten) begin
              man_act_d = 1'b1;
              man_lvl_d = inten;
              apply     = 1'b1;
            end
          end else if (!auto_act_q || auto_lvl_q != inten) begin
            auto_act_d = 1'b1;
            auto_lvl_d = inten;
            apply      = 1'b1;
          end
        end else begin
          if (item_q.flash_source == plmc_pkg::SRC_MANUAL) begin
            if (man_act_q) begin
              man_act_d = 1'b0;
              apply     = 1'b1;
            end
          end else if (auto_act_q) begin
            auto_act_d = 1'b0;
            apply      = 1'b1;
          end
        end

        // Requests stay held during OTA; manual wins over automatic.
        if (apply && mode_q != plmc_pkg::MODE_OTA) begin
          if (man_act_d || auto_act_d) begin
            req_lvl = man_act_d ? man_lvl_d : auto_lvl_d;
            if (mode_q != plmc_pkg::MODE_FLASH) begin
              mode_d        = plmc_pkg::MODE_FLASH;
              flash_shown_d = '0;
            end
            if (req_lvl != flash_shown_d) begin
              flash_shown_d = req_lvl;
              wrote         = (last_lvl_q != req_lvl);
              last_lvl_d    = req_lvl;
            end
          end else if (mode_q == plmc_pkg::MODE_FLASH) begin
            mode_d        = plmc_pkg::MODE_STATUS;
            status_on_d   = 1'b0;
            status_last_d = '0;
          end
        end
      end

      plmc_pkg::CMD_OTA_UPDATE: begin
        if (mode_q == plmc_pkg::MODE_OTA && ota_due) begin
          ota_on_d   = !ota_on_q;
          drive_lvl  = ota_on_d ? ota_lit_level : '0;
          wrote      = (last_lvl_q != drive_lvl);
          last_lvl_d = drive_lvl;
          ota_last_d = now;
        end
      end

      default: ;
    endcase

    result_d.pwm_written    = wrote;
    result_d.pwm_level      = plmc_pkg::LEVEL_W'(last_lvl_d);
    result_d.active_mode    = mode_d;
    result_d.change_blocked = blocked;
  end

  // Control and mode state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      mode_q        <= plmc_pkg::MODE_STATUS;
      status_on_q   <= 1'b0;
      status_last_q <= '0;
      flash_shown_q <= '0;
      ota_on_q      <= 1'b0;
      ota_last_q    <= '0;
      man_act_q     <= 1'b0;
      man_lvl_q     <= '0;
      auto_act_q    <= 1'b0;
      auto_lvl_q    <= '0;
      last_lvl_q    <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        mode_q        <= mode_d;
        status_on_q   <= status_on_d;
        status_last_q <= status_last_d;
        flash_shown_q <= flash_shown_d;
        ota_on_q      <= ota_on_d;
        ota_last_q    <= ota_last_d;
        man_act_q     <= man_act_d;
        man_lvl_q     <= man_lvl_d;
        auto_act_q    <= auto_act_d;
        auto_lvl_q    <= auto_lvl_d;
        last_lvl_q    <= last_lvl_d;
      end
    end
  end

  // Payload registers of the input and result stages.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.mode         <= in_i.mode;
      item_q.target_mode  <= in_i.target_mode;
      item_q.connected    <= in_i.connected;
      item_q.enabled      <= in_i.enabled;
      item_q.lit          <= in_i.lit;
      item_q.brightness   <= in_i.brightness;
      item_q.flash_source <= in_i.flash_source;
      item_q.intensity    <= in_i.intensity;
      item_q.time_ms      <= in_i.time_ms;
    end
    if (fire) begin
      result_q <= result_d;
    end
  end

  // Result channel.
  assign out_o.valid          = out_valid_q;
  assign out_o.pwm_written    = result_q.pwm_written;
  assign out_o.pwm_level      = result_q.pwm_level;
  assign out_o.active_mode    = result_q.active_mode;
  assign out_o.change_blocked = result_q.change_blocked;

`ifndef SYNTH
  // The reported mode is always one of the three modes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.active_mode != 2'd3)
    else $error("active mode code out of range");

  // Only a set mode command can be refused by priority.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_q.mode != 3'(plmc_pkg::CMD_SET_MODE)) |-> !blocked)
    else $error("blocked flag raised by a non set mode command");

  // Status commands write nothing outside status mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && mode_q != plmc_pkg::MODE_STATUS &&
     (item_q.mode == 3'(plmc_pkg::CMD_STATUS_UPDATE) ||
      item_q.mode == 3'(plmc_pkg::CMD_STATUS_DIRECT))) |-> !wrote)
    else $error("status command wrote PWM outside status mode");

  // A reported write always changes the driven level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (!result_q.pwm_written || last_lvl_q != $past(last_lvl_q)))
    else $error("PWM write reported without a level change");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench of the priority LED mode controller.
`timescale 1ns / 1ps

module tb_top;
  import plmc_pkg::*;

  // Command and target codes that the package leaves without a name.
  localparam logic [2:0] CMD_UNUSED    = 3'd7;
  localparam logic [1:0] TARGET_UNUSED = 2'd3;
  localparam logic       SRC_AUTO      = !SRC_MANUAL;
  localparam out_item_t  NO_RES        = '0;
  localparam int unsigned ITEMS_PER_PHASE = 400;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel_i;
  logic               penable_i;
  logic               pwrite_i;
  logic [PADDR_W-1:0] paddr_i;
  logic [31:0]        pwdata_i;
  logic [31:0]        prdata_o;
  logic               pready_o;

  plmc_in_if  in_if ();
  plmc_out_if out_if ();

  priority_led_mode_controller u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // Predictor copy of the block's registers and mode state.
  logic [INTERVAL_W-1:0] cfg_status_ivl = STATUS_INTERVAL_RST;
  logic [INTERVAL_W-1:0] cfg_ota_ivl    = OTA_INTERVAL_RST;
  logic [LEVEL_W-1:0]    cfg_ota_lvl    = OTA_LEVEL_RST;
  led_mode_e             cur_mode       = MODE_STATUS;
  logic                  st_on          = 1'b0;
  logic [TIME_MS_W-1:0]  st_last        = '0;
  logic [LEVEL_W-1:0]    fl_shown       = '0;
  logic                  ota_on         = 1'b0;
  logic [TIME_MS_W-1:0]  ota_last       = '0;
  logic                  man_on         = 1'b0;
  logic [LEVEL_W-1:0]    man_lvl        = '0;
  logic                  auto_on        = 1'b0;
  logic [LEVEL_W-1:0]    auto_lvl       = '0;
  logic [LEVEL_W-1:0]    lvl_last       = '0;
  logic                  wrote          = 1'b0;

  out_item_t            pending_led_q[$];
  logic [TIME_MS_W-1:0] now_ms   = '0;
  bit                   no_idle  = 1'b0;
  int unsigned          fails    = 0;
  int unsigned          n_sent   = 0;
  int unsigned          n_checked = 0;
  int unsigned          n_written = 0;
  int unsigned          n_blocked = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // A PWM write happens only when the level changes.
  function automatic void drive_level(logic [LEVEL_W-1:0] lvl);
    if (lvl != lvl_last) begin
      lvl_last = lvl;
      wrote    = 1'b1;
    end
  endfunction

  // Mode entry with priority; returns one when the request is refused.
  function automatic bit switch_mode(logic [1:0] want);
    if (want > MODE_OTA || want == cur_mode) return 1'b0;
    if (want != MODE_STATUS && want < cur_mode) return 1'b1;
    cur_mode = led_mode_e'(want);
    case (cur_mode)
      MODE_STATUS: begin
        st_on   = 1'b0;
        st_last = '0;
      end
      MODE_FLASH: fl_shown = '0;
      default: begin
        ota_on   = 1'b0;
        ota_last = '0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void show_flash(logic [LEVEL_W-1:0] lvl);
    if (cur_mode == MODE_FLASH && lvl != fl_shown) begin
      fl_shown = lvl;
      drive_level(lvl);
    end
  endfunction

  // Manual request beats automatic; with neither held, flash falls back to status.
  function automatic void refresh_flash();
    if (cur_mode == MODE_OTA) return;
    if (man_on) begin
      void'(switch_mode(MODE_FLASH));
      show_flash(man_lvl);
    end else if (auto_on) begin
      void'(switch_mode(MODE_FLASH));
      show_flash(auto_lvl);
    end else if (cur_mode == MODE_FLASH) begin
      void'(switch_mode(MODE_STATUS));
    end
  endfunction

  // Expected result of one command, advancing the predictor state.
  function automatic out_item_t predict_led(in_item_t it);
    logic [TIME_MS_W-1:0] elapsed;
    bit                   blocked;
    out_item_t            res;
    wrote   = 1'b0;
    blocked = 1'b0;
    case (it.mode)
      CMD_SET_MODE: blocked = switch_mode(it.target_mode);
      CMD_STATUS_UPDATE: begin
        if (cur_mode == MODE_STATUS) begin
          elapsed = it.time_ms - st_last;
          if (!it.enabled || it.brightness == '0) begin
            drive_level('0);
            st_on = 1'b0;
          end else if (it.connected) begin
            if (!st_on) begin
              drive_level(it.brightness);
              st_on = 1'b1;
            end
          end else if (elapsed >= TIME_MS_W'(cfg_status_ivl)) begin
            st_on = !st_on;
            drive_level(st_on ? it.brightness : '0);
            st_last = it.time_ms;
          end
        end
      end
      CMD_STATUS_DIRECT: begin
        if (cur_mode == MODE_STATUS) begin
          st_on = it.lit;
          drive_level(it.lit ? it.brightness : '0);
        end
      end
      CMD_FLASH_REQUEST: begin
        if (it.flash_source == SRC_MANUAL) begin
          if (!man_on || man_lvl != it.intensity) begin
            man_on  = 1'b1;
            man_lvl = it.intensity;
            refresh_flash();
          end
        end else if (!auto_on || auto_lvl != it.intensity) begin
          auto_on  = 1'b1;
          auto_lvl = it.intensity;
          refresh_flash();
        end
      end
      CMD_FLASH_RELEASE: begin
        if (it.flash_source == SRC_MANUAL) begin
          if (man_on) begin
            man_on = 1'b0;
            refresh_flash();
          end
        end else if (auto_on) begin
          auto_on = 1'b0;
          refresh_flash();
        end
      end
      CMD_FLASH_REFRESH: refresh_flash();
      CMD_OTA_UPDATE: begin
        if (cur_mode == MODE_OTA) begin
          elapsed = it.time_ms - ota_last;
          if (elapsed >= TIME_MS_W'(cfg_ota_ivl)) begin
            ota_on = !ota_on;
            drive_level(ota_on ? cfg_ota_lvl : '0);
            ota_last = it.time_ms;
          end
        end
      end
      default: ;
    endcase
    res.pwm_written    = wrote;
    res.pwm_level      = lvl_last;
    res.active_mode    = cur_mode;
    res.change_blocked = blocked;
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return LEVEL_W'($urandom_range(3));
    return LEVEL_W'($urandom());
  endfunction

  // Random command, weighted toward the ones that move the LED state.
  function automatic in_item_t rand_item();
    in_item_t              it;
    int unsigned           r;
    logic [INTERVAL_W-1:0] ivl;
    r = $urandom_range(99);
    if (r < 14) it.mode = CMD_SET_MODE;
    else if (r < 38) it.mode = CMD_STATUS_UPDATE;
    else if (r < 48) it.mode = CMD_STATUS_DIRECT;
    else if (r < 63) it.mode = CMD_FLASH_REQUEST;
    else if (r < 76) it.mode = CMD_FLASH_RELEASE;
    else if (r < 84) it.mode = CMD_FLASH_REFRESH;
    else if (r < 98) it.mode = CMD_OTA_UPDATE;
    else it.mode = CMD_UNUSED;
    it.target_mode  = ($urandom_range(9) == 0) ? TARGET_UNUSED : 2'($urandom_range(2));
    it.connected    = 1'($urandom_range(1));
    it.enabled      = ($urandom_range(7) != 0);
    it.lit          = 1'($urandom_range(1));
    it.brightness   = pick_level();
    it.flash_source = 1'($urandom_range(1));
    it.intensity    = pick_level();
    // Time mostly moves forward by about one interval, with rare jumps.
    ivl = (it.mode == CMD_OTA_UPDATE) ? cfg_ota_ivl : cfg_status_ivl;
    r = $urandom_range(59);
    if (r == 0) now_ms = $urandom();
    else if (r == 1) now_ms = '1 - TIME_MS_W'($urandom_range(200));
    else now_ms = now_ms + TIME_MS_W'($urandom_range(2 * int'(ivl)));
    it.time_ms = now_ms;
    return it;
  endfunction

  function automatic dir_row_t dir_row(logic [2:0] c, logic [1:0] tg, logic cn, logic en,
                                       logic lt, logic [7:0] br, logic src, logic [7:0] inten,
                                       logic [31:0] tm, bit typed, out_item_t want);
    dir_row_t row_v;
    row_v.item  = '{c, tg, cn, en, lt, br, src, inten, tm};
    row_v.typed = typed;
    row_v.want  = want;
    return row_v;
  endfunction

  // Sends one command after an idle gap and records its expected result.
  task automatic send_item(input in_item_t it, input int unsigned gap, input bit typed,
                           input out_item_t typed_res);
    out_item_t model_res;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    {in_if.mode, in_if.target_mode, in_if.connected, in_if.enabled, in_if.lit,
     in_if.brightness, in_if.flash_source, in_if.intensity, in_if.time_ms} <= it;
    do @(posedge clk_i); while (!in_if.ready);
    model_res = predict_led(it);
    pending_led_q.push_back(typed ? typed_res : model_res);
    n_sent++;
  endtask

  // Holds off the sender until every pending result has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_led_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= PADDR_W'({idx, 2'b00});
    pwdata_i  <= wdata;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rdata = prdata_o;
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes a register, updates the predictor and checks the read back.
  task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    case (idx)
      REG_STATUS_INTERVAL: cfg_status_ivl = value[INTERVAL_W-1:0];
      REG_OTA_INTERVAL:    cfg_ota_ivl    = value[INTERVAL_W-1:0];
      REG_OTA_LEVEL:       cfg_ota_lvl    = value[LEVEL_W-1:0];
      default: ;
    endcase
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== value) begin
      $error("prdata of register %0d: expected %0d, actual %0d", idx, value, rd);
      fails++;
    end
  endtask

  // Result side: random stalls and in-order comparison.
  initial begin : result_check
    out_item_t   got;
    out_item_t   want;
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got = '{out_if.pwm_written, out_if.pwm_level, out_if.active_mode,
                out_if.change_blocked};
        if (pending_led_q.size() == 0) begin
          $error("result transaction with no command pending");
          fails++;
        end else begin
          want = pending_led_q.pop_front();
          n_checked++;
          if (got.pwm_written === 1'b1) n_written++;
          if (got.change_blocked === 1'b1) n_blocked++;
          if (got.pwm_written !== want.pwm_written) begin
            $error("pwm_written: expected %0d, actual %0d", want.pwm_written, got.pwm_written);
            fails++;
          end
          if (got.pwm_level !== want.pwm_level) begin
            $error("pwm_level: expected %0d, actual %0d", want.pwm_level, got.pwm_level);
            fails++;
          end
          if (got.active_mode !== want.active_mode) begin
            $error("active_mode: expected %0d, actual %0d", want.active_mode, got.active_mode);
            fails++;
          end
          if (got.change_blocked !== want.change_blocked) begin
            $error("change_blocked: expected %0d, actual %0d", want.change_blocked,
                   got.change_blocked);
            fails++;
          end
        end
      end
      if (stall_left == 0 && $urandom_range(3) == 0) stall_left = pick_gap();
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed commands, then random phases over several settings.
  initial begin : stimulus
    dir_row_t    dir_tab[$];
    int unsigned ph;
    int unsigned n;
    logic [31:0] s_ivl;
    logic [31:0] o_ivl;
    logic [31:0] o_lvl;

    rst_ni      <= 1'b0;
    psel_i      <= 1'b0;
    penable_i   <= 1'b0;
    pwrite_i    <= 1'b0;
    paddr_i     <= '0;
    pwdata_i    <= '0;
    in_if.valid <= 1'b0;
    {in_if.mode, in_if.target_mode, in_if.connected, in_if.enabled, in_if.lit,
     in_if.brightness, in_if.flash_source, in_if.intensity, in_if.time_ms} <= '0;

    // Directed commands under the reset register values.
    dir_tab = '{
      dir_row(CMD_STATUS_UPDATE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b1, '{1'b0, 8'd0, MODE_STATUS, 1'b0}),
      dir_row(CMD_STATUS_DIRECT, MODE_STATUS, 0, 1, 1, 8'd255, SRC_MANUAL, 8'd0, 32'd0,
              1'b1, '{1'b1, 8'd255, MODE_STATUS, 1'b0}),
      dir_row(CMD_STATUS_DIRECT, MODE_STATUS, 0, 1, 0, 8'd255, SRC_MANUAL, 8'd0, 32'd0,
              1'b1, '{1'b1, 8'd0, MODE_STATUS, 1'b0}),
      dir_row(CMD_STATUS_UPDATE, MODE_STATUS, 1, 1, 0, 8'd1, SRC_MANUAL, 8'd0, 32'd0,
              1'b1, '{1'b1, 8'd1, MODE_STATUS, 1'b0}),
      dir_row(CMD_STATUS_UPDATE, MODE_STATUS, 0, 1, 0, 8'd200, SRC_MANUAL, 8'd0,
              32'hFFFF_FFFF, 1'b0, NO_RES),
      dir_row(CMD_STATUS_UPDATE, MODE_STATUS, 0, 1, 0, 8'd200, SRC_MANUAL, 8'd0,
              32'h0000_01F3, 1'b0, NO_RES),
      dir_row(CMD_SET_MODE, TARGET_UNUSED, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_SET_MODE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_FLASH_REQUEST, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_STATUS_DIRECT, MODE_STATUS, 0, 0, 1, 8'd77, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_FLASH_REQUEST, MODE_STATUS, 0, 0, 0, 8'd0, SRC_AUTO, 8'd255, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_FLASH_RELEASE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_FLASH_REFRESH, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_SET_MODE, MODE_OTA, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_SET_MODE, MODE_FLASH, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b1, '{1'b0, 8'd255, MODE_OTA, 1'b1}),
      dir_row(CMD_FLASH_REQUEST, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd7, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_OTA_UPDATE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd100,
              1'b0, NO_RES),
      dir_row(CMD_OTA_UPDATE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd150,
              1'b0, NO_RES),
      dir_row(CMD_OTA_UPDATE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd200,
              1'b0, NO_RES),
      dir_row(CMD_STATUS_UPDATE, MODE_STATUS, 1, 1, 0, 8'd9, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_UNUSED, MODE_STATUS, 1, 1, 1, 8'd255, SRC_AUTO, 8'd255, 32'hFFFF_FFFF,
              1'b0, NO_RES),
      dir_row(CMD_FLASH_REFRESH, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_SET_MODE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_FLASH_REFRESH, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_FLASH_RELEASE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_MANUAL, 8'd0, 32'd0,
              1'b0, NO_RES),
      dir_row(CMD_FLASH_RELEASE, MODE_STATUS, 0, 0, 0, 8'd0, SRC_AUTO, 8'd0, 32'd0,
              1'b0, NO_RES)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].item, pick_gap(), dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          s_ivl = 32'd1;
          o_ivl = 32'd1;
          o_lvl = 32'd0;
        end
        1: begin
          s_ivl = 32'd65535;
          o_ivl = 32'd65535;
          o_lvl = 32'd255;
        end
        2: begin
          s_ivl = $urandom_range(1000, 2);
          o_ivl = $urandom_range(1000, 2);
          o_lvl = $urandom_range(254, 1);
        end
        3: begin
          s_ivl = $urandom_range(65535, 1);
          o_ivl = $urandom_range(65535, 1);
          o_lvl = $urandom_range(255);
        end
        default: begin
          s_ivl = 32'd65535;
          o_ivl = 32'd1;
          o_lvl = $urandom_range(255);
        end
      endcase
      set_register(REG_STATUS_INTERVAL, s_ivl);
      set_register(REG_OTA_INTERVAL, o_ivl);
      set_register(REG_OTA_LEVEL, o_lvl);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        no_idle = (n % 200) < 40;
        if ($urandom_range(199) == 0) wait_drained();
        send_item(rand_item(), pick_gap(), 1'b0, NO_RES);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d commands (%0d directed) under six register settings.",
             n_sent, dir_tab.size());
    $display("Checked %0d results: %0d PWM writes, %0d refused mode changes.",
             n_checked, n_written, n_blocked);
    if (fails == 0 && pending_led_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
